>>> design/bse_pkg.sv
// Shared widths and register indexes for the binomial series evaluator.
package bse_pkg;

  localparam int X_W     = 31;
  localparam int SUM_W   = 48;
  localparam int TERMS_W = 8;
  localparam int EPS_W   = 32;
  localparam int MAXT_W  = 8;

  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 32;

  localparam logic [CFG_IDX_W-1:0] CFG_EPSILON   = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_TERMS = 1'b1;

  localparam logic [EPS_W-1:0]  EPS_RESET  = 32'd4295;
  localparam logic [MAXT_W-1:0] MAXT_RESET = 8'd64;

  typedef logic signed [X_W-1:0]   x_t;
  typedef logic signed [SUM_W-1:0] sum_t;
  typedef logic [TERMS_W-1:0]      terms_t;

endpackage

>>> design/bse_ifs.sv
// Valid/ready channel interfaces for the argument and result words.
interface bse_in_if import bse_pkg::*; ();
  logic valid;
  logic ready;
  x_t   x;

  modport source (output valid, output x, input ready);
  modport sink   (input valid, input x, output ready);
endinterface

interface bse_out_if import bse_pkg::*; ();
  logic   valid;
  logic   ready;
  sum_t   sum;
  terms_t terms_used;
  logic   hit_accuracy;
  logic   hit_max_terms;

  modport source (output valid, output sum, output terms_used, output hit_accuracy,
                  output hit_max_terms, input ready);
  modport sink   (input valid, input sum, input terms_used, input hit_accuracy,
                  input hit_max_terms, output ready);
endinterface

>>> design/binomial_series_evaluator.sv
// Top level: iterative binomial series evaluator for (1 - x)^(-1/4).
//
// The argument arrives as one word on in_ch (signed Q1.30) and the result leaves as one
// word on out_ch: a saturated Q16.32 sum, the count of terms used and the two stop flags.
// Both channels move a word when valid and ready are high at the same rising edge.
// The threshold and the term limit are written through cfg_we/cfg_index/cfg_wdata. The
// user must write them only while the block is idle, which the block does not enforce;
// written so, they take effect for the next word accepted. One word is worked on at a
// time: in_ch.ready is high only in the idle state. Each term runs through one shared
// 16-bit-slice multiplier and a radix-2 restoring divider; the multiplier takes its b
// operand in NCH 16-bit slices, where NCH is the number of 16-bit slices of the widest
// multiplier operand. A word stops after at most 255 terms with the default parameters.
// The result sits in an output register; the block goes back to idle as soon as that
// register has been loaded, so a new word may be accepted while the result waits. If the
// receiver still stalls the previous result when a new one is ready, the sequencer holds
// in its last state until the output register frees up. Reset (rst_n low at a clock edge)
// returns the sequencer to idle, drops out_ch.valid and restores the register defaults.
module binomial_series_evaluator import bse_pkg::*; #(
  parameter int TERM_LIMIT = 255,
  parameter int FRAC_BITS  = 32
) (
  input  logic                  clk,
  input  logic                  rst_n,
  bse_in_if.sink                in_ch,
  bse_out_if.source             out_ch,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  localparam int F   = FRAC_BITS;
  // term counter holds the limit itself; 4*k fits two bits wider
  localparam int TW  = $clog2(TERM_LIMIT + 1);
  localparam int KW  = TW + 2;
  localparam int BW0 = (F + 1 > X_W) ? F + 1 : X_W;
  localparam int BW  = (BW0 > KW) ? BW0 : KW;
  localparam int NCH = (BW + 15) / 16;
  localparam int BP  = NCH * 16;
  localparam int PW  = F + 1 + BP;
  localparam int JW  = $clog2(NCH);
  localparam int DW  = $clog2(F + 1);
  localparam int SW  = F + TW + 2;
  // conversion of the sum to 32 fraction bits
  localparam int UP  = (F < 32) ? 32 - F : 0;
  localparam int DN  = (F > 32) ? F - 32 : 0;
  localparam int CW0 = SW + UP + 1;
  localparam int CW2 = (CW0 > SUM_W + 1) ? CW0 : SUM_W + 1;
  // threshold comparison width and alignment
  localparam int EW  = (F >= 32) ? F + 1 : 33;
  localparam int LS  = (F < 32) ? 32 - F : 0;
  localparam int RS  = (F >= 32) ? F - 32 : 0;

  localparam logic [CW2-1:0] RND_CONV = (DN > 0) ? (CW2'(1) << ((DN > 0) ? DN - 1 : 0)) : '0;
  localparam logic [CW2-1:0] SAT_NEG  = CW2'(1) << (SUM_W - 1);
  localparam logic [CW2-1:0] SAT_POS  = (CW2'(1) << (SUM_W - 1)) - CW2'(1);
  localparam logic [F:0]     ONE_Q    = (F + 1)'(1) << F;

  // sequencer states
  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_CHECK = 4'd1;
  localparam logic [3:0] S_MUL   = 4'd2;
  localparam logic [3:0] S_RND   = 4'd3;
  localparam logic [3:0] S_DIV   = 4'd4;
  localparam logic [3:0] S_ACC   = 4'd5;
  localparam logic [3:0] S_FIN1  = 4'd6;
  localparam logic [3:0] S_FIN2  = 4'd7;
  localparam logic [3:0] S_FIN3  = 4'd8;

  // what the shared multiplier is working on
  localparam logic [1:0] MOP_COEF = 2'd0;  // coef * (4k - 3), numerator of the ratio
  localparam logic [1:0] MOP_POW  = 2'd1;  // |x|^(k-1) * |x|
  localparam logic [1:0] MOP_TERM = 2'd2;  // coef * |x|^k

  logic [3:0]           state_r, state_nxt;
  logic [EPS_W-1:0]     cfg_eps_r;
  logic [MAXT_W-1:0]    cfg_mt_r;
  logic                 neg_r, neg_nxt;
  logic [X_W-1:0]       ax_r, ax_nxt;
  logic [F:0]           coef_r, coef_nxt;
  logic [F:0]           pw_r, pw_nxt;
  logic [F:0]           t_r, t_nxt;
  logic signed [SW-1:0] sum_r, sum_nxt;
  logic [TW-1:0]        terms_r, terms_nxt;
  logic                 hit_r, hit_nxt;
  logic [1:0]           mop_r, mop_nxt;
  logic [F:0]           a_r, a_nxt;
  logic [BP-1:0]        b_r, b_nxt;
  logic [PW-1:0]        acc_r, acc_nxt;
  logic [JW-1:0]        j_r, j_nxt;
  logic [KW-1:0]        rem_r, rem_nxt;
  logic [F:0]           q_r, q_nxt;
  logic [DW-1:0]        dc_r, dc_nxt;
  logic [SW-1:0]        mag_r, mag_nxt;
  logic                 sneg_r, sneg_nxt;
  logic [CW2-1:0]       conv_r, conv_nxt;

  logic                 out_valid_r, out_valid_nxt;
  sum_t                 out_sum_r, out_sum_nxt;
  terms_t               out_terms_r, out_terms_nxt;
  logic                 out_acc_r, out_acc_nxt;
  logic                 out_max_r, out_max_nxt;

  logic [TW-1:0]        lim;
  logic [KW-1:0]        k4;
  logic [F+16:0]        prod;
  logic [PW-1:0]        rnd_add, rnd_sum;
  logic [KW:0]          trial;
  logic                 qbit;
  logic [CW2-1:0]       clamped;
  logic [X_W-1:0]       xr;
  logic                 in_fire;

  // Effective term limit: zero counts as one, anything above TERM_LIMIT is cut to it.
  always_comb begin
    if (cfg_mt_r == '0) begin
      lim = TW'(1);
    end else if (32'(cfg_mt_r) > 32'(TERM_LIMIT)) begin
      lim = TW'(TERM_LIMIT);
    end else begin
      lim = TW'(cfg_mt_r);
    end
  end

  assign k4      = {terms_r, 2'b00};
  assign in_fire = in_ch.valid && in_ch.ready;
  assign xr      = in_ch.x;

  // Shared multiplier: one 16-bit slice of b per cycle, most significant slice first.
  assign prod = a_r * b_r[BP-1 -: 16];

  // One rounding adder serves all three multiplier results: for the ratio numerator it
  // adds the half divisor 2k, for the power the half unit of Q1.30, for the term the half
  // unit of the coefficient format.
  always_comb begin
    unique case (mop_r)
      MOP_POW:  rnd_add = PW'(1) << 29;
      MOP_TERM: rnd_add = PW'(1) << (F - 1);
      default:  rnd_add = PW'({terms_r, 1'b0});
    endcase
  end
  assign rnd_sum = acc_r + rnd_add;

  // Restoring divider step by 4k.
  assign trial = {rem_r, q_r[F]} - {1'b0, k4};
  assign qbit  = !trial[KW];

  always_comb begin
    if (sneg_r) begin
      clamped = (conv_r > SAT_NEG) ? SAT_NEG : conv_r;
    end else begin
      clamped = (conv_r > SAT_POS) ? SAT_POS : conv_r;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    neg_nxt       = neg_r;
    ax_nxt        = ax_r;
    coef_nxt      = coef_r;
    pw_nxt        = pw_r;
    t_nxt         = t_r;
    sum_nxt       = sum_r;
    terms_nxt     = terms_r;
    hit_nxt       = hit_r;
    mop_nxt       = mop_r;
    a_nxt         = a_r;
    b_nxt         = b_r;
    acc_nxt       = acc_r;
    j_nxt         = j_r;
    rem_nxt       = rem_r;
    q_nxt         = q_r;
    dc_nxt        = dc_r;
    mag_nxt       = mag_r;
    sneg_nxt      = sneg_r;
    conv_nxt      = conv_r;
    out_sum_nxt   = out_sum_r;
    out_terms_nxt = out_terms_r;
    out_acc_nxt   = out_acc_r;
    out_max_nxt   = out_max_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;

    unique case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          neg_nxt   = xr[X_W-1];
          ax_nxt    = xr[X_W-1] ? X_W'(33'h0_8000_0000 - {2'b00, xr}) : xr;
          coef_nxt  = ONE_Q;
          pw_nxt    = ONE_Q;
          sum_nxt   = SW'(1) << F;
          terms_nxt = TW'(1);
          hit_nxt   = 1'b0;
          state_nxt = S_CHECK;
        end
      end
      S_CHECK: begin
        if ((terms_r < lim) && !hit_r) begin
          mop_nxt   = MOP_COEF;
          a_nxt     = coef_r;
          b_nxt     = BP'(k4 - KW'(3));
          acc_nxt   = '0;
          j_nxt     = JW'(NCH - 1);
          state_nxt = S_MUL;
        end else begin
          state_nxt = S_FIN1;
        end
      end
      S_MUL: begin
        acc_nxt = (acc_r << 16) + PW'(prod);
        b_nxt   = b_r << 16;
        if (j_r == '0) begin
          state_nxt = S_RND;
        end else begin
          j_nxt = j_r - JW'(1);
        end
      end
      S_RND: begin
        unique case (mop_r)
          MOP_COEF: begin
            rem_nxt   = rnd_sum[F+1 +: KW];
            q_nxt     = rnd_sum[F:0];
            dc_nxt    = DW'(F);
            state_nxt = S_DIV;
          end
          MOP_POW: begin
            pw_nxt    = rnd_sum[30 +: F+1];
            mop_nxt   = MOP_TERM;
            a_nxt     = coef_r;
            b_nxt     = BP'(rnd_sum[30 +: F+1]);
            acc_nxt   = '0;
            j_nxt     = JW'(NCH - 1);
            state_nxt = S_MUL;
          end
          MOP_TERM: begin
            t_nxt     = rnd_sum[F +: F+1];
            state_nxt = S_ACC;
          end
          default: begin
            state_nxt = S_IDLE;
          end
        endcase
      end
      S_DIV: begin
        rem_nxt = qbit ? trial[KW-1:0] : {rem_r[KW-2:0], q_r[F]};
        q_nxt   = {q_r[F-1:0], qbit};
        if (dc_r == '0) begin
          coef_nxt  = {q_r[F-1:0], qbit};
          mop_nxt   = MOP_POW;
          a_nxt     = pw_r;
          b_nxt     = BP'(ax_r);
          acc_nxt   = '0;
          j_nxt     = JW'(NCH - 1);
          state_nxt = S_MUL;
        end else begin
          dc_nxt = dc_r - DW'(1);
        end
      end
      S_ACC: begin
        // odd powers of a negative argument subtract
        if (neg_r && terms_r[0]) begin
          sum_nxt = sum_r - $signed(SW'(t_r));
        end else begin
          sum_nxt = sum_r + $signed(SW'(t_r));
        end
        hit_nxt   = (EW'(t_r) << LS) <= (EW'(cfg_eps_r) << RS);
        terms_nxt = terms_r + TW'(1);
        state_nxt = S_CHECK;
      end
      S_FIN1: begin
        sneg_nxt  = sum_r[SW-1];
        mag_nxt   = sum_r[SW-1] ? SW'(-sum_r) : SW'(sum_r);
        state_nxt = S_FIN2;
      end
      S_FIN2: begin
        conv_nxt  = ((CW2'(mag_r) + RND_CONV) >> DN) << UP;
        state_nxt = S_FIN3;
      end
      S_FIN3: begin
        if (!out_valid_r || out_ch.ready) begin
          out_sum_nxt   = sneg_r ? sum_t'(-clamped[SUM_W-1:0]) : sum_t'(clamped[SUM_W-1:0]);
          out_terms_nxt = TERMS_W'(terms_r);
          out_acc_nxt   = hit_r;
          out_max_nxt   = (terms_r == lim);
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      cfg_eps_r   <= EPS_RESET;
      cfg_mt_r    <= MAXT_RESET;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        if (cfg_index == CFG_EPSILON) begin
          cfg_eps_r <= cfg_wdata[EPS_W-1:0];
        end else if (cfg_index == CFG_MAX_TERMS) begin
          cfg_mt_r <= cfg_wdata[MAXT_W-1:0];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    neg_r       <= neg_nxt;
    ax_r        <= ax_nxt;
    coef_r      <= coef_nxt;
    pw_r        <= pw_nxt;
    t_r         <= t_nxt;
    sum_r       <= sum_nxt;
    terms_r     <= terms_nxt;
    hit_r       <= hit_nxt;
    mop_r       <= mop_nxt;
    a_r         <= a_nxt;
    b_r         <= b_nxt;
    acc_r       <= acc_nxt;
    j_r         <= j_nxt;
    rem_r       <= rem_nxt;
    q_r         <= q_nxt;
    dc_r        <= dc_nxt;
    mag_r       <= mag_nxt;
    sneg_r      <= sneg_nxt;
    conv_r      <= conv_nxt;
    out_sum_r   <= out_sum_nxt;
    out_terms_r <= out_terms_nxt;
    out_acc_r   <= out_acc_nxt;
    out_max_r   <= out_max_nxt;
  end

  assign in_ch.ready          = (state_r == S_IDLE);
  assign out_ch.valid         = out_valid_r;
  assign out_ch.sum           = out_sum_r;
  assign out_ch.terms_used    = out_terms_r;
  assign out_ch.hit_accuracy  = out_acc_r;
  assign out_ch.hit_max_terms = out_max_r;

`ifndef SYNTH
  // A word that has just been taken leaves the block busy in the cycle after.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> !in_ch.ready)
    else $error("input accepted on two consecutive cycles");

  // A new result only appears when the sequencer leaves its final state.
  a_result_from_fin: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> ($past(state_r) == S_FIN3))
    else $error("result raised outside the final state");

  // At least the leading term is always counted.
  a_terms_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_terms_r != '0))
    else $error("result reports zero terms");
`endif

endmodule
